/* sv/sdspi_pkg.sv */
package sdspi_pkg;

    localparam int unsigned SectorBytesDefault = 512;

    // Sequencer phases, one-hot.
    typedef enum logic [22:0] {
        PH_IDLE      = 23'd1 << 0,
        PH_POWER     = 23'd1 << 1,
        PH_DUMMY     = 23'd1 << 2,
        PH_CMD0      = 23'd1 << 3,
        PH_CMD8      = 23'd1 << 4,
        PH_R7        = 23'd1 << 5,
        PH_SD2_55    = 23'd1 << 6,
        PH_SD2_41    = 23'd1 << 7,
        PH_SD2_WAIT  = 23'd1 << 8,
        PH_CMD58     = 23'd1 << 9,
        PH_OCR       = 23'd1 << 10,
        PH_PROBE55   = 23'd1 << 11,
        PH_PROBE41   = 23'd1 << 12,
        PH_SD1_55    = 23'd1 << 13,
        PH_SD1_41    = 23'd1 << 14,
        PH_SD1_WAIT  = 23'd1 << 15,
        PH_MMC_1     = 23'd1 << 16,
        PH_MMC_WAIT  = 23'd1 << 17,
        PH_CMD16_SD1 = 23'd1 << 18,
        PH_CMD16_MMC = 23'd1 << 19,
        PH_CMD17     = 23'd1 << 20,
        PH_TOKEN     = 23'd1 << 21,
        PH_DATA      = 23'd1 << 22
    } phase_t;

    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOCARD = 2'd1;
    localparam logic [1:0] ST_RDERR  = 2'd2;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_MMC   = 3'd1;
    localparam logic [2:0] KIND_SD1   = 3'd2;
    localparam logic [2:0] KIND_SD2B  = 3'd3;
    localparam logic [2:0] KIND_SD2HC = 3'd4;

    localparam logic [2:0] CFG_READY_POLL = 3'd0;
    localparam logic [2:0] CFG_TOKEN_WAIT = 3'd1;
    localparam logic [2:0] CFG_RESP_WAIT  = 3'd2;
    localparam logic [2:0] CFG_DUMMY      = 3'd3;
    localparam logic [2:0] CFG_POWER_UP   = 3'd4;

    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_OP_MMC   = 6'd1;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_READ1    = 6'd17;
    localparam logic [5:0] CMD_OP_SD    = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN = 8'hFE;

endpackage

/* sv/sd_card_spi_host_engine.sv */
// Channel  | Direction | Contents
// s_axis   | in        | tuser: action; tdata: card_present, sector, offset, count, rx_byte
// m_axis   | out       | tuser: tx_valid, select, data_valid, done_res; tdata: tx_byte,
//          |           |        wait_ticks, data_byte, status, card_kind
// cfg      | in        | cfg_index selects a limit register, cfg_data is the new value
// Each item is decided combinationally; an item is taken every cycle while the output
// register is empty or being drained. Items that cause no result leave no output.
// aresetn is synchronous and active low; it clears the phase and counters and returns
// the limits to their defaults.
// A stall on m_axis holds the output register and stops s_axis only when it is full.
module sd_card_spi_host_engine
    import sdspi_pkg::*;
#(
    parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] card_present, [32:1] sector, [41:33] offset, [51:42] count, [59:52] rx_byte
    input  logic [63:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [17:8] wait_ticks, [25:18] data_byte, [27:26] status,
    // [30:28] card_kind
    output logic [31:0] m_axis_tdata,
    // [0] tx_valid, [1] select, [2] data_valid, [3] done_res
    output logic [3:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(SECTOR_BYTES + 3);

    logic [15:0] ready_poll_reg, token_wait_reg;
    logic [7:0]  resp_wait_reg, dummy_reg;
    logic [9:0]  power_up_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  fpos_reg, fpos_next;
    logic [5:0]  cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic [15:0] retry_reg, retry_next;
    logic [15:0] poll_reg, poll_next;
    logic [CW-1:0] bcnt_reg, bcnt_next;
    logic [7:0]  reply_reg [4];
    logic        reply_we;
    logic [CW-1:0] first_reg, first_next, end_reg, end_next;

    logic        ovalid_reg;
    logic [31:0] odata_reg;
    logic [3:0]  ouser_reg;

    logic        any, txv, sel, dv, done;
    logic [7:0]  txb, db;
    logic [9:0]  wt;
    logic [1:0]  st;

    logic        take;
    logic [1:0]  action;
    logic        present;
    logic [31:0] sector;
    logic [8:0]  offset;
    logic [9:0]  count;
    logic [7:0]  rx;

    assign action  = s_axis_tuser;
    assign present = s_axis_tdata[0];
    assign sector  = s_axis_tdata[32:1];
    assign offset  = s_axis_tdata[41:33];
    assign count   = s_axis_tdata[51:42];
    assign rx      = s_axis_tdata[59:52];

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Command frame byte at a given position.
    function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [5:0] c,
                                              input logic [31:0] a);
        logic [7:0] b;
        case (pos)
            3'd0: b = {2'b01, c};
            3'd1: b = a[31:24];
            3'd2: b = a[23:16];
            3'd3: b = a[15:8];
            3'd4: b = a[7:0];
            default: b = (c == CMD_GO_IDLE) ? 8'h95 : (c == CMD_IF_COND) ? 8'h87 : 8'h01;
        endcase
        return b;
    endfunction

    // Next-state decision for one item.
    always_comb begin
        logic [15:0] poll_inc;
        logic [CW-1:0] bcnt_inc;
        logic [31:0] lba;
        logic        fin_fail;
        logic        start;
        logic [5:0]  sc;
        logic [31:0] sa;
        logic        finish;
        logic [1:0]  fst;
        phase_t      sph;

        phase_next = phase_reg; kind_next = kind_reg; fpos_next = fpos_reg;
        cmd_next = cmd_reg; arg_next = arg_reg; retry_next = retry_reg;
        poll_next = poll_reg; bcnt_next = bcnt_reg; first_next = first_reg;
        end_next = end_reg; reply_we = 1'b0;
        any = 1'b0; txv = 1'b0; txb = 8'd0; sel = 1'b0; wt = 10'd0;
        dv = 1'b0; db = 8'd0; done = 1'b0; st = ST_OK;
        start = 1'b0; sc = CMD_GO_IDLE; sa = 32'd0; sph = PH_IDLE;
        finish = 1'b0; fst = ST_OK; fin_fail = 1'b0;
        poll_inc = poll_reg + 16'd1;
        bcnt_inc = bcnt_reg + CW'(1);
        lba = (kind_reg == KIND_SD2HC) ? sector : sector * 32'(SECTOR_BYTES);

        case (action)
            ACT_INIT: if (phase_reg == PH_IDLE) begin
                kind_next = KIND_NONE;
                if (!present) begin
                    finish = 1'b1; fst = ST_NOCARD;
                end else if (power_up_reg == 10'd0) begin
                    phase_next = PH_DUMMY; bcnt_next = '0;
                    if (dummy_reg == 8'd0) begin
                        start = 1'b1; sph = PH_CMD0; sc = CMD_GO_IDLE;
                    end else begin
                        any = 1'b1; txv = 1'b1; txb = BYTE_IDLE;
                    end
                end else begin
                    phase_next = PH_POWER; bcnt_next = '0;
                    any = 1'b1; wt = power_up_reg;
                end
            end
            ACT_READ: if (phase_reg == PH_IDLE) begin
                if (kind_reg == KIND_NONE) begin
                    finish = 1'b1; fst = ST_NOCARD;
                end else if (count == 10'd0 ||
                             (CW+1)'({1'b0, offset} + {1'b0, count}) >
                             (CW+1)'(SECTOR_BYTES)) begin
                    finish = 1'b1; fst = ST_RDERR;
                end else begin
                    first_next = CW'(offset);
                    end_next   = CW'({1'b0, offset} + {1'b0, count});
                    start = 1'b1; sph = PH_CMD17; sc = CMD_READ1; sa = lba;
                end
            end
            ACT_REPLY: begin
                unique case (phase_reg)
                    PH_IDLE, PH_POWER, PH_SD2_WAIT, PH_SD1_WAIT, PH_MMC_WAIT: ;
                    PH_DUMMY: begin
                        bcnt_next = bcnt_inc;
                        if (bcnt_inc < CW'(dummy_reg)) begin
                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE;
                        end else begin
                            start = 1'b1; sph = PH_CMD0; sc = CMD_GO_IDLE;
                        end
                    end
                    PH_R7, PH_OCR: begin
                        reply_we = 1'b1;
                        bcnt_next = bcnt_inc;
                        if (bcnt_inc < CW'(4)) begin
                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE; sel = 1'b1;
                        end else if (phase_reg == PH_OCR) begin
                            kind_next = reply_reg[0][6] ? KIND_SD2HC : KIND_SD2B;
                            finish = 1'b1;
                        end else if (reply_reg[2] == 8'h01 && rx == 8'hAA) begin
                            retry_next = '0;
                            start = 1'b1; sph = PH_SD2_55; sc = CMD_APP;
                        end else fin_fail = 1'b1;
                    end
                    PH_TOKEN: begin
                        poll_next = poll_inc;
                        if (rx == BYTE_IDLE && poll_inc < token_wait_reg) begin
                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE; sel = 1'b1;
                        end else if (rx == BYTE_TOKEN) begin
                            phase_next = PH_DATA; bcnt_next = '0;
                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE; sel = 1'b1;
                        end else begin
                            finish = 1'b1; fst = ST_RDERR;
                        end
                    end
                    PH_DATA: begin
                        any = 1'b1;
                        if (bcnt_reg >= first_reg && bcnt_reg < end_reg) begin
                            dv = 1'b1; db = rx;
                        end
                        bcnt_next = bcnt_inc;
                        if (bcnt_inc >= CW'(SECTOR_BYTES + 2)) finish = 1'b1;
                        else begin
                            txv = 1'b1; txb = BYTE_IDLE; sel = 1'b1;
                        end
                    end
                    default: begin
                        // Command frame, response poll and response handling.
                        if (fpos_reg < 3'd5) begin
                            fpos_next = fpos_reg + 3'd1;
                            any = 1'b1; txv = 1'b1; sel = 1'b1;
                            txb = frame_byte(fpos_reg + 3'd1, cmd_reg, arg_reg);
                        end else if (fpos_reg == 3'd5) begin
                            fpos_next = 3'd6; poll_next = '0;
                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE; sel = 1'b1;
                        end else begin
                            poll_next = poll_inc;
                            if (rx[7] && poll_inc < {8'd0, resp_wait_reg}) begin
                                any = 1'b1; txv = 1'b1; txb = BYTE_IDLE; sel = 1'b1;
                            end else begin
                                case (phase_reg)
                                    PH_CMD0:
                                        if (rx == 8'd1) begin
                                            start = 1'b1; sph = PH_CMD8;
                                            sc = CMD_IF_COND; sa = 32'h1AA;
                                        end else fin_fail = 1'b1;
                                    PH_CMD8:
                                        if (rx == 8'd1) begin
                                            phase_next = PH_R7; bcnt_next = '0;
                                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE;
                                            sel = 1'b1;
                                        end else begin
                                            start = 1'b1; sph = PH_PROBE55; sc = CMD_APP;
                                        end
                                    PH_SD2_55:
                                        if (rx > 8'd1) begin
                                            retry_next = retry_reg + 16'd1;
                                            phase_next = PH_SD2_WAIT;
                                            any = 1'b1; wt = 10'd1; sel = 1'b1;
                                        end else begin
                                            start = 1'b1; sph = PH_SD2_41; sc = CMD_OP_SD;
                                            sa = 32'h4000_0000;
                                        end
                                    PH_SD2_41:
                                        if (rx == 8'd0) begin
                                            start = 1'b1; sph = PH_CMD58;
                                            sc = CMD_READ_OCR;
                                        end else begin
                                            retry_next = retry_reg + 16'd1;
                                            phase_next = PH_SD2_WAIT;
                                            any = 1'b1; wt = 10'd1; sel = 1'b1;
                                        end
                                    PH_CMD58:
                                        if (rx == 8'd0) begin
                                            phase_next = PH_OCR; bcnt_next = '0;
                                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE;
                                            sel = 1'b1;
                                        end else fin_fail = 1'b1;
                                    PH_PROBE55:
                                        if (rx > 8'd1) begin
                                            retry_next = '0; start = 1'b1;
                                            sph = PH_MMC_1; sc = CMD_OP_MMC;
                                        end else begin
                                            start = 1'b1; sph = PH_PROBE41; sc = CMD_OP_SD;
                                        end
                                    PH_PROBE41:
                                        if (rx <= 8'd1) begin
                                            retry_next = '0; start = 1'b1;
                                            sph = PH_SD1_55; sc = CMD_APP;
                                        end else begin
                                            retry_next = '0; start = 1'b1;
                                            sph = PH_MMC_1; sc = CMD_OP_MMC;
                                        end
                                    PH_SD1_55:
                                        if (rx > 8'd1) begin
                                            retry_next = retry_reg + 16'd1;
                                            phase_next = PH_SD1_WAIT;
                                            any = 1'b1; wt = 10'd1; sel = 1'b1;
                                        end else begin
                                            start = 1'b1; sph = PH_SD1_41; sc = CMD_OP_SD;
                                        end
                                    PH_SD1_41:
                                        if (rx == 8'd0) begin
                                            start = 1'b1; sph = PH_CMD16_SD1;
                                            sc = CMD_BLOCKLEN; sa = 32'(SECTOR_BYTES);
                                        end else begin
                                            retry_next = retry_reg + 16'd1;
                                            phase_next = PH_SD1_WAIT;
                                            any = 1'b1; wt = 10'd1; sel = 1'b1;
                                        end
                                    PH_MMC_1:
                                        if (rx == 8'd0) begin
                                            start = 1'b1; sph = PH_CMD16_MMC;
                                            sc = CMD_BLOCKLEN; sa = 32'(SECTOR_BYTES);
                                        end else begin
                                            retry_next = retry_reg + 16'd1;
                                            phase_next = PH_MMC_WAIT;
                                            any = 1'b1; wt = 10'd1; sel = 1'b1;
                                        end
                                    PH_CMD16_SD1, PH_CMD16_MMC:
                                        if (rx == 8'd0) begin
                                            kind_next = (phase_reg == PH_CMD16_SD1) ?
                                                        KIND_SD1 : KIND_MMC;
                                            finish = 1'b1;
                                        end else fin_fail = 1'b1;
                                    PH_CMD17:
                                        if (rx == 8'd0) begin
                                            phase_next = PH_TOKEN; poll_next = '0;
                                            any = 1'b1; txv = 1'b1; txb = BYTE_IDLE;
                                            sel = 1'b1;
                                        end else begin
                                            finish = 1'b1; fst = ST_RDERR;
                                        end
                                    default: begin
                                        finish = 1'b1; fst = ST_RDERR;
                                    end
                                endcase
                            end
                        end
                    end
                endcase
            end
            default: begin
                // Tick.
                case (phase_reg)
                    PH_POWER: begin
                        bcnt_next = bcnt_inc;
                        if (13'(bcnt_inc) >= 13'(power_up_reg)) begin
                            phase_next = PH_DUMMY; bcnt_next = '0;
                            if (dummy_reg == 8'd0) begin
                                start = 1'b1; sph = PH_CMD0; sc = CMD_GO_IDLE;
                            end else begin
                                any = 1'b1; txv = 1'b1; txb = BYTE_IDLE;
                            end
                        end
                    end
                    PH_SD2_WAIT, PH_SD1_WAIT, PH_MMC_WAIT: begin
                        if (retry_reg >= ready_poll_reg) fin_fail = 1'b1;
                        else begin
                            start = 1'b1;
                            if (phase_reg == PH_SD2_WAIT) begin
                                sph = PH_SD2_55; sc = CMD_APP;
                            end else if (phase_reg == PH_SD1_WAIT) begin
                                sph = PH_SD1_55; sc = CMD_APP;
                            end else begin
                                sph = PH_MMC_1; sc = CMD_OP_MMC;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        endcase

        if (start) begin
            phase_next = sph; cmd_next = sc; arg_next = sa; fpos_next = 3'd0;
            any = 1'b1; txv = 1'b1; sel = 1'b1; txb = frame_byte(3'd0, sc, sa);
        end
        if (fin_fail) begin
            kind_next = KIND_NONE; finish = 1'b1; fst = ST_NOCARD;
        end
        if (finish) begin
            phase_next = PH_IDLE; any = 1'b1; done = 1'b1; st = fst; sel = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_poll_reg <= 16'd10000;
            token_wait_reg <= 16'd40000;
            resp_wait_reg  <= 8'd255;
            dummy_reg      <= 8'd10;
            power_up_reg   <= 10'd1000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_READY_POLL: ready_poll_reg <= cfg_data;
                CFG_TOKEN_WAIT: token_wait_reg <= cfg_data;
                CFG_RESP_WAIT:  resp_wait_reg  <= cfg_data[7:0];
                CFG_DUMMY:      dummy_reg      <= cfg_data[7:0];
                CFG_POWER_UP:   power_up_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; kind_reg <= KIND_NONE; fpos_reg <= '0;
            cmd_reg <= '0; arg_reg <= '0; retry_reg <= '0; poll_reg <= '0;
            bcnt_reg <= '0; first_reg <= '0; end_reg <= '0; ovalid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next; kind_reg <= kind_next; fpos_reg <= fpos_next;
                cmd_reg <= cmd_next; arg_reg <= arg_next; retry_reg <= retry_next;
                poll_reg <= poll_next; bcnt_reg <= bcnt_next;
                first_reg <= first_next; end_reg <= end_next;
            end
            if (take) ovalid_reg <= any;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    // Reply byte store and output payload.
    always_ff @(posedge aclk) begin
        if (take && reply_we) reply_reg[bcnt_reg[1:0]] <= rx;
        if (take && any) begin
            odata_reg <= {1'b0, kind_next, st, db, wt, txb};
            ouser_reg <= {done, dv, sel, txv};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

/* sv/sdspi_checker.sv */
module sdspi_checker
    import sdspi_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    // Input is always ready when the output side is empty.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready) else $error("input stalled while empty");

    // A finished request deselects the card.
    a_done_desel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[3] |-> !m_axis_tuser[1])
        else $error("select held at finish");

    // Status is only nonzero on a finish.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata[27:26] == ST_OK)
        else $error("status without finish");

    // A held item stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule

bind sd_card_spi_host_engine sdspi_checker u_sdspi_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

/* sim/sd_card_spi_host_engine_tb.sv */
module sd_card_spi_host_engine_tb;
    import sdspi_pkg::*;

    localparam logic [7:0]  START_BITS   = 8'h40;
    localparam logic [7:0]  CRC_GO_IDLE  = 8'h95;
    localparam logic [7:0]  CRC_IF_COND  = 8'h87;
    localparam logic [7:0]  CRC_OTHER    = 8'h01;
    localparam logic [7:0]  R7_VOLTAGE   = 8'h01;
    localparam logic [7:0]  R7_PATTERN   = 8'hAA;
    localparam logic [7:0]  R1_IDLE      = 8'h01;
    localparam logic [7:0]  R1_READY     = 8'h00;
    localparam logic [7:0]  R1_ILLEGAL   = 8'h05;
    localparam logic [7:0]  BUSY_BIT     = 8'h80;
    localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG      = 32'h4000_0000;
    localparam int unsigned SECTOR       = SectorBytesDefault;

    typedef struct packed {
        logic [1:0]  action;
        logic        present;
        logic [31:0] sector;
        logic [8:0]  offset;
        logic [9:0]  count;
        logic [7:0]  rx;
    } card_event_t;

    typedef struct packed {
        logic       txv;
        logic [7:0] txb;
        logic       sel;
        logic [9:0] wt;
        logic       dv;
        logic [7:0] db;
        logic       done;
        logic [1:0] st;
        logic [2:0] kind;
        bit         any;
    } host_step_t;

    typedef struct packed {
        card_event_t ev;
        bit          typed;
        host_step_t  want;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    sd_card_spi_host_engine dut (.*);

    always #4 aclk = ~aclk;

    // Shadow of the limit registers.
    logic [15:0] lim_ready = 16'd10000;
    logic [15:0] lim_token = 16'd40000;
    logic [7:0]  lim_resp  = 8'd255;
    logic [7:0]  lim_dummy = 8'd10;
    logic [9:0]  lim_power = 10'd1000;

    // Predicted sequencer state.
    phase_t      p_ph = PH_IDLE;
    logic [2:0]  p_kind = KIND_NONE;
    logic [2:0]  p_fpos = '0;
    logic [5:0]  p_cmd = '0;
    logic [31:0] p_arg = '0;
    logic [15:0] p_retry = '0;
    logic [15:0] p_poll = '0;
    logic [9:0]  p_cnt = '0;
    logic [7:0]  p_reply [4];
    logic [9:0]  p_first = '0;
    logic [9:0]  p_end = '0;
    host_step_t  nx;

    // Behavior of the emulated card for the current init.
    logic [2:0]  card_kind_emu = KIND_SD2HC;
    bit          card_flaky = 1'b0;

    host_step_t  pending_q [$];
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors = 0;
    int          sent = 0;

    function automatic logic [7:0] frame_byte(input logic [2:0] pos);
        case (pos)
            3'd0: return START_BITS | {2'b00, p_cmd};
            3'd1: return p_arg[31:24];
            3'd2: return p_arg[23:16];
            3'd3: return p_arg[15:8];
            3'd4: return p_arg[7:0];
            default: begin
                if (p_cmd == CMD_GO_IDLE) return CRC_GO_IDLE;
                if (p_cmd == CMD_IF_COND) return CRC_IF_COND;
                return CRC_OTHER;
            end
        endcase
    endfunction

    task automatic xchg(input logic [7:0] b, input logic sel);
        nx.txv = 1'b1; nx.txb = b; nx.sel = sel; nx.any = 1'b1;
    endtask

    task automatic hold_ticks(input logic [9:0] t, input logic sel);
        nx.wt = t; nx.sel = sel; nx.any = 1'b1;
    endtask

    task automatic finish_req(input logic [1:0] st);
        p_ph = PH_IDLE; nx.done = 1'b1; nx.st = st; nx.sel = 1'b0; nx.any = 1'b1;
    endtask

    task automatic fail_init();
        p_kind = KIND_NONE;
        finish_req(ST_NOCARD);
    endtask

    task automatic start_cmd(input phase_t ph, input logic [5:0] idx, input logic [31:0] arg);
        p_ph = ph; p_cmd = idx; p_arg = arg; p_fpos = '0;
        xchg(frame_byte(3'd0), 1'b1);
    endtask

    task automatic start_trail(input phase_t ph);
        p_ph = ph; p_cnt = '0;
        xchg(BYTE_IDLE, 1'b1);
    endtask

    task automatic retry_later(input phase_t ph);
        p_retry++;
        p_ph = ph;
        hold_ticks(10'd1, 1'b1);
    endtask

    task automatic start_dummy();
        p_ph = PH_DUMMY; p_cnt = '0;
        if (lim_dummy == 0) start_cmd(PH_CMD0, CMD_GO_IDLE, '0);
        else xchg(BYTE_IDLE, 1'b0);
    endtask

    task automatic mmc_loop();
        p_retry = '0;
        start_cmd(PH_MMC_1, CMD_OP_MMC, '0);
    endtask

    // Decision on a command response byte.
    task automatic on_response(input logic [7:0] rx);
        case (p_ph)
            PH_CMD0:
                if (rx == R1_IDLE) start_cmd(PH_CMD8, CMD_IF_COND, IF_COND_ARG);
                else fail_init();
            PH_CMD8:
                if (rx == R1_IDLE) start_trail(PH_R7);
                else start_cmd(PH_PROBE55, CMD_APP, '0);
            PH_SD2_55:
                if (rx > R1_IDLE) retry_later(PH_SD2_WAIT);
                else start_cmd(PH_SD2_41, CMD_OP_SD, HCS_ARG);
            PH_SD2_41:
                if (rx == R1_READY) start_cmd(PH_CMD58, CMD_READ_OCR, '0);
                else retry_later(PH_SD2_WAIT);
            PH_CMD58:
                if (rx == R1_READY) start_trail(PH_OCR);
                else fail_init();
            PH_PROBE55:
                if (rx > R1_IDLE) mmc_loop();
                else start_cmd(PH_PROBE41, CMD_OP_SD, '0);
            PH_PROBE41:
                if (rx <= R1_IDLE) begin
                    p_retry = '0;
                    start_cmd(PH_SD1_55, CMD_APP, '0);
                end else begin
                    mmc_loop();
                end
            PH_SD1_55:
                if (rx > R1_IDLE) retry_later(PH_SD1_WAIT);
                else start_cmd(PH_SD1_41, CMD_OP_SD, '0);
            PH_SD1_41:
                if (rx == R1_READY) start_cmd(PH_CMD16_SD1, CMD_BLOCKLEN, SECTOR);
                else retry_later(PH_SD1_WAIT);
            PH_MMC_1:
                if (rx == R1_READY) start_cmd(PH_CMD16_MMC, CMD_BLOCKLEN, SECTOR);
                else retry_later(PH_MMC_WAIT);
            PH_CMD16_SD1, PH_CMD16_MMC:
                if (rx == R1_READY) begin
                    p_kind = (p_ph == PH_CMD16_SD1) ? KIND_SD1 : KIND_MMC;
                    finish_req(ST_OK);
                end else begin
                    fail_init();
                end
            PH_CMD17:
                if (rx == R1_READY) begin
                    p_ph = PH_TOKEN; p_poll = '0;
                    xchg(BYTE_IDLE, 1'b1);
                end else begin
                    finish_req(ST_RDERR);
                end
            default: finish_req(ST_RDERR);
        endcase
    endtask

    // A byte came back from the card.
    task automatic on_reply(input logic [7:0] rx);
        case (p_ph)
            PH_IDLE, PH_POWER, PH_SD2_WAIT, PH_SD1_WAIT, PH_MMC_WAIT: ;
            PH_DUMMY: begin
                p_cnt++;
                if (p_cnt < lim_dummy) xchg(BYTE_IDLE, 1'b0);
                else start_cmd(PH_CMD0, CMD_GO_IDLE, '0);
            end
            PH_R7, PH_OCR: begin
                p_reply[p_cnt[1:0]] = rx;
                p_cnt++;
                if (p_cnt < 4) begin
                    xchg(BYTE_IDLE, 1'b1);
                end else if (p_ph == PH_OCR) begin
                    p_kind = p_reply[0][6] ? KIND_SD2HC : KIND_SD2B;
                    finish_req(ST_OK);
                end else if (p_reply[2] == R7_VOLTAGE && p_reply[3] == R7_PATTERN) begin
                    p_retry = '0;
                    start_cmd(PH_SD2_55, CMD_APP, '0);
                end else begin
                    fail_init();
                end
            end
            PH_TOKEN: begin
                p_poll++;
                if (rx == BYTE_IDLE && p_poll < lim_token) begin
                    xchg(BYTE_IDLE, 1'b1);
                end else if (rx == BYTE_TOKEN) begin
                    p_ph = PH_DATA; p_cnt = '0;
                    xchg(BYTE_IDLE, 1'b1);
                end else begin
                    finish_req(ST_RDERR);
                end
            end
            PH_DATA: begin
                if (p_cnt >= p_first && p_cnt < p_end) begin
                    nx.dv = 1'b1; nx.db = rx; nx.any = 1'b1;
                end
                p_cnt++;
                if (p_cnt >= SECTOR + 2) finish_req(ST_OK);
                else xchg(BYTE_IDLE, 1'b1);
            end
            default: begin
                // Command frame out, then poll for the response.
                if (p_fpos < 5) begin
                    p_fpos++;
                    xchg(frame_byte(p_fpos), 1'b1);
                end else if (p_fpos == 5) begin
                    p_fpos = 3'd6; p_poll = '0;
                    xchg(BYTE_IDLE, 1'b1);
                end else begin
                    p_poll++;
                    if (rx[7] && p_poll < lim_resp) xchg(BYTE_IDLE, 1'b1);
                    else on_response(rx);
                end
            end
        endcase
    endtask

    task automatic on_tick();
        case (p_ph)
            PH_POWER: begin
                p_cnt++;
                if (p_cnt >= lim_power) start_dummy();
            end
            PH_SD2_WAIT:
                if (p_retry >= lim_ready) fail_init();
                else start_cmd(PH_SD2_55, CMD_APP, '0);
            PH_SD1_WAIT:
                if (p_retry >= lim_ready) fail_init();
                else start_cmd(PH_SD1_55, CMD_APP, '0);
            PH_MMC_WAIT:
                if (p_retry >= lim_ready) fail_init();
                else start_cmd(PH_MMC_1, CMD_OP_MMC, '0);
            default: ;
        endcase
    endtask

    // Work out the result of one accepted item into nx.
    task automatic predict_step(input card_event_t ev);
        logic [10:0] win_end;
        win_end = {2'b00, ev.offset} + {1'b0, ev.count};
        nx = '0;
        case (ev.action)
            ACT_INIT:
                if (p_ph == PH_IDLE) begin
                    p_kind = KIND_NONE;
                    if (!ev.present) begin
                        finish_req(ST_NOCARD);
                    end else if (lim_power == 0) begin
                        start_dummy();
                    end else begin
                        p_ph = PH_POWER; p_cnt = '0;
                        hold_ticks(lim_power, 1'b0);
                    end
                end
            ACT_READ:
                if (p_ph == PH_IDLE) begin
                    if (p_kind == KIND_NONE) begin
                        finish_req(ST_NOCARD);
                    end else if (ev.count == 0 || win_end > SECTOR) begin
                        finish_req(ST_RDERR);
                    end else begin
                        p_first = {1'b0, ev.offset};
                        p_end = win_end[9:0];
                        start_cmd(PH_CMD17, CMD_READ1,
                                  (p_kind == KIND_SD2HC) ? ev.sector : (ev.sector << 9));
                    end
                end
            ACT_REPLY: on_reply(ev.rx);
            default: on_tick();
        endcase
        nx.kind = p_kind;
    endtask

    // Response byte the emulated card gives in a command phase.
    function automatic logic [7:0] card_response();
        bit coin;
        coin = ($urandom_range(2) == 0);
        case (p_ph)
            PH_CMD0:       return (card_flaky && coin) ? 8'($urandom_range(127)) : R1_IDLE;
            PH_CMD8:       return (card_kind_emu >= KIND_SD2B) ? R1_IDLE : R1_ILLEGAL;
            PH_SD2_55,
            PH_SD1_55:     return ($urandom_range(5) == 0) ? R1_ILLEGAL : 8'($urandom_range(1));
            PH_SD2_41,
            PH_SD1_41,
            PH_MMC_1:      return coin ? R1_READY : R1_IDLE;
            PH_PROBE55:    return (card_kind_emu == KIND_MMC) ? R1_ILLEGAL : R1_IDLE;
            PH_PROBE41:    return (card_kind_emu == KIND_MMC) ? R1_ILLEGAL
                                                              : 8'($urandom_range(1));
            PH_CMD58, PH_CMD16_SD1, PH_CMD16_MMC, PH_CMD17:
                           return (card_flaky && coin) ? R1_ILLEGAL : R1_READY;
            default:       return R1_READY;
        endcase
    endfunction

    // Choose the next item from the predicted state: mostly a well-behaved card.
    task automatic pick_event(output card_event_t ev);
        ev.action = ACT_REPLY;
        ev.present = 1'($urandom);
        ev.sector = $urandom;
        ev.offset = 9'($urandom);
        ev.count = 10'($urandom);
        ev.rx = 8'($urandom);
        if ($urandom_range(24) == 0) begin
            ev.action = 2'($urandom);
        end else begin
            case (p_ph)
                PH_IDLE:
                    if (p_kind == KIND_NONE || $urandom_range(1)) begin
                        ev.action = ACT_INIT;
                        ev.present = ($urandom_range(9) != 0);
                        card_kind_emu = 3'($urandom_range(KIND_MMC, KIND_SD2HC));
                        card_flaky = ($urandom_range(3) == 0);
                    end else begin
                        ev.action = ACT_READ;
                        case ($urandom_range(9))
                            0: begin ev.offset = '0; ev.count = 10'(SECTOR); end
                            1: begin ev.offset = 9'd511; ev.count = 10'd1; end
                            2: ev.count = '0;
                            3: ev.count = 10'($urandom_range(SECTOR + 1 - ev.offset, 1023));
                            default: ev.count = 10'($urandom_range(1, SECTOR - ev.offset));
                        endcase
                        case ($urandom_range(5))
                            0: ev.sector = '0;
                            1: ev.sector = '1;
                            default: ;
                        endcase
                    end
                PH_POWER, PH_SD2_WAIT, PH_SD1_WAIT, PH_MMC_WAIT: ev.action = ACT_TICK;
                PH_DUMMY, PH_DATA: ;
                PH_R7:
                    if (!(card_flaky && $urandom_range(2) == 0)) begin
                        if (p_cnt == 2) ev.rx = R7_VOLTAGE;
                        if (p_cnt == 3) ev.rx = R7_PATTERN;
                    end
                PH_OCR:
                    if (p_cnt == 0) ev.rx[6] = (card_kind_emu == KIND_SD2HC);
                PH_TOKEN:
                    if (card_flaky && $urandom_range(7) == 0) ;
                    else ev.rx = ($urandom_range(3) == 0) ? BYTE_TOKEN : BYTE_IDLE;
                default:
                    if (p_fpos == 6) begin
                        if ($urandom_range(3) == 0) ev.rx = ev.rx | BUSY_BIT;
                        else ev.rx = card_response();
                    end
            endcase
        end
    endtask

    // Offer one item, wait for it to be taken, record what it should cause.
    task automatic send_event(input card_event_t ev, input bit typed, input host_step_t want);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ev.action;
        s_axis_tdata <= {4'b0, ev.rx, ev.count, ev.offset, ev.sector, ev.present};
        do @(posedge aclk); while (!s_axis_tready);
        sent++;
        predict_step(ev);
        if (nx.any) pending_q.push_back(typed ? want : nx);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [15:0] v_ready, input logic [15:0] v_token,
                                input logic [7:0] v_resp, input logic [7:0] v_dummy,
                                input logic [9:0] v_power);
        logic [15:0] vals [5];
        vals = '{v_ready, v_token, {8'b0, v_resp}, {8'b0, v_dummy}, {6'b0, v_power}};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        lim_ready = v_ready; lim_token = v_token; lim_resp = v_resp;
        lim_dummy = v_dummy; lim_power = v_power;
    endtask

    // Receiver stalls.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checker.
    always @(posedge aclk) begin
        host_step_t exp_r;
        host_step_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.txv = m_axis_tuser[0];
            got.sel = m_axis_tuser[1];
            got.dv = m_axis_tuser[2];
            got.done = m_axis_tuser[3];
            got.txb = m_axis_tdata[7:0];
            got.wt = m_axis_tdata[17:8];
            got.db = m_axis_tdata[25:18];
            got.st = m_axis_tdata[27:26];
            got.kind = m_axis_tdata[30:28];
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected item: tuser %h tdata %h",
                                           m_axis_tuser, m_axis_tdata);
            end else begin
                exp_r = pending_q.pop_front();
                if (got.txv !== exp_r.txv || got.txb !== exp_r.txb || got.sel !== exp_r.sel ||
                    got.wt !== exp_r.wt || got.dv !== exp_r.dv || got.db !== exp_r.db ||
                    got.done !== exp_r.done || got.st !== exp_r.st ||
                    got.kind !== exp_r.kind) begin
                    errors++;
                    if (errors <= 10)
                        $display({"Mismatch: exp txv %0d txb %h sel %0d wait %0d dv %0d db %h ",
                                  "done %0d st %0d kind %0d / got txv %0d txb %h sel %0d ",
                                  "wait %0d dv %0d db %h done %0d st %0d kind %0d"},
                                 exp_r.txv, exp_r.txb, exp_r.sel, exp_r.wt, exp_r.dv,
                                 exp_r.db, exp_r.done, exp_r.st, exp_r.kind, got.txv,
                                 got.txb, got.sel, got.wt, got.dv, got.db, got.done,
                                 got.st, got.kind);
                end
            end
        end
    end

    // Main sequence.
    initial begin
        script_row_t script [$];
        host_step_t  r_nocard;
        host_step_t  r_power;
        card_event_t ev;
        int          n;

        r_nocard = '0; r_nocard.done = 1'b1; r_nocard.st = ST_NOCARD; r_nocard.any = 1'b1;
        r_power = '0; r_power.wt = 10'd3; r_power.any = 1'b1;

        // Directed opening: stray events, requests without a card, busy requests.
        script.push_back('{'{ACT_TICK, 1'b1, 32'hFFFF_FFFF, 9'h1FF, 10'h3FF, 8'hFF}, 0, '0});
        script.push_back('{'{ACT_REPLY, 1'b0, 32'h0, 9'h0, 10'h0, 8'h00}, 0, '0});
        script.push_back('{'{ACT_READ, 1'b1, 32'hFFFF_FFFF, 9'd511, 10'd1, 8'h00}, 1, r_nocard});
        script.push_back('{'{ACT_INIT, 1'b0, 32'hFFFF_FFFF, 9'h1FF, 10'h3FF, 8'hFF}, 1, r_nocard});
        script.push_back('{'{ACT_READ, 1'b0, 32'h0, 9'd0, 10'd512, 8'hFF}, 1, r_nocard});
        script.push_back('{'{ACT_INIT, 1'b1, 32'h0, 9'h0, 10'h0, 8'h00}, 1, r_power});
        script.push_back('{'{ACT_REPLY, 1'b1, 32'h0, 9'h0, 10'h0, 8'h01}, 0, '0});
        script.push_back('{'{ACT_INIT, 1'b1, 32'h0, 9'h0, 10'h0, 8'h00}, 0, '0});
        script.push_back('{'{ACT_READ, 1'b1, 32'h1, 9'd0, 10'd0, 8'h00}, 0, '0});
        script.push_back('{'{ACT_TICK, 1'b0, 32'h0, 9'h0, 10'h0, 8'h00}, 0, '0});

        send_idle = 22;
        recv_idle = 69;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short limits keep the opening init brief.
        write_limits(16'd4, 16'd40, 8'd8, 8'd4, 10'd3);

        foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);
        // Let the card model carry the opening init to its end.
        while (p_ph != PH_IDLE) begin
            pick_event(ev);
            send_event(ev, 0, '0);
        end

        for (int mode = 0; mode < 3; mode++) begin
            drain();
            case (mode)
                0: write_limits(16'hFFFF, 16'hFFFF, 8'hFF, 8'd2, 10'd2);
                1: begin
                    write_limits('0, '0, '0, '0, '0);
                    send_idle = 69;
                    recv_idle = 22;
                end
                default: begin
                    write_limits(16'($urandom_range(1, 4)), 16'($urandom_range(2, 20)),
                                 8'($urandom_range(2, 8)), 8'($urandom_range(1, 12)),
                                 10'($urandom_range(1, 5)));
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            n = 0;
            while (n < 60 || sent < 250 * (mode + 1) || p_ph != PH_IDLE) begin
                pick_event(ev);
                send_event(ev, 0, '0);
                n++;
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
